// File: rtl/angle_distance_height_meter_assert.svh
// Assertion macros shared by the meter's RTL files.
`ifndef ANGLE_DISTANCE_HEIGHT_METER_ASSERT_SVH
`define ANGLE_DISTANCE_HEIGHT_METER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ADHM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adhm assertion failed");
// Next-cycle implication, disabled during reset.
`define ADHM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adhm assertion failed");
`else
`define ADHM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ADHM_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/adhm_pkg.sv
// Shared constants and types of the angle distance height meter.
`timescale 1ns / 1ps
`default_nettype none
package adhm_pkg;
  localparam int ANGLE_W = 25;                 // reduced angle magnitude in (0, 1.4]
  localparam logic signed [31:0] LIM_Q24 = 32'sd23488102;
  localparam logic signed [31:0] HALFPI_Q24 = 32'sd26353589;
  localparam int TAN_FRAC = 28;
  localparam logic [63:0] ONE_Q28 = 64'd1 << TAN_FRAC;
  localparam logic [63:0] TAN_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam logic [39:0] OUT_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [63:0] DIST_LIMIT = 64'd1 << 52;
  localparam int SH_W = 23;
  localparam logic [SH_W-1:0] SH_RESET = 23'd98304;
  localparam int CF_DEPTH_DEF = 9;
  localparam int QDEPTH = 2;
  localparam logic REG_SENSOR_HEIGHT = 1'b0;

  typedef struct packed {
    logic                bad;
    logic                has_b;
    logic [ANGLE_W-1:0]  ra;
    logic [ANGLE_W-1:0]  rb;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/adhm_front.sv
// Front end: accepts beats, folds angles into the first quadrant, classifies them.
`timescale 1ns / 1ps
`default_nettype none
module adhm_front
  import adhm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic signed [31:0] angle_a,
  input  wire logic signed [31:0] angle_b,
  input  wire logic               has_angle_b,
  input  wire logic               q_full,
  output logic                    q_push,
  output entry_t                  q_data
);
  logic               busy;
  logic signed [31:0] a_r;
  logic signed [31:0] b_r;
  logic               hb_r;
  logic               a_big;
  logic               b_big;

  assign a_big = a_r > LIM_Q24;
  assign b_big = hb_r && (b_r > LIM_Q24);
  assign item_stall = busy;
  assign q_push = busy && !a_big && !b_big && !q_full;

  always_comb begin
    q_data.bad   = (a_r <= 32'sd0) || (hb_r && (b_r <= 32'sd0));
    q_data.has_b = hb_r;
    q_data.ra    = a_r[ANGLE_W-1:0];
    q_data.rb    = b_r[ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!busy) begin
      if (item_valid) begin
        busy <= 1'b1;
        a_r  <= angle_a;
        b_r  <= angle_b;
        hb_r <= has_angle_b;
      end
    end else begin
      if (a_big) a_r <= a_r - HALFPI_Q24;
      if (b_big) b_r <= b_r - HALFPI_Q24;
      if (q_push) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: rtl/adhm_queue.sv
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
`include "angle_distance_height_meter_assert.svh"
module adhm_queue
  import adhm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t wdata,
  output logic        full,
  input  wire logic   pop,
  output logic        empty,
  output entry_t      rdata
);
  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  entry_t             slots [QDEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;

  assign full  = count == CNT_W'(QDEPTH);
  assign empty = count == '0;
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `ADHM_ASSERT_IMP(a_no_push_full, clk, rst, push, !full || pop)
  `ADHM_ASSERT_IMP(a_no_pop_empty, clk, rst, pop, !empty)
endmodule
`default_nettype wire

// File: rtl/adhm_div.sv
// Radix-2 restoring divider, 64 by 64 bits, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "angle_distance_height_meter_assert.svh"
module adhm_div
  import adhm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic        busy;
  logic        done;
  logic [6:0]  cnt;
  logic [64:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [64:0] shifted;
  logic        fits;

  assign shifted = {rem[63:0], quo[63]};
  assign fits = shifted >= {1'b0, dvs};
  assign rsp.quotient = quo;
  assign rsp.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (req.start) begin
          busy <= 1'b1;
          cnt  <= 7'd64;
          rem  <= '0;
          quo  <= req.dividend;
          dvs  <= req.divisor;
        end
      end else begin
        rem <= fits ? shifted - {1'b0, dvs} : shifted;
        quo <= {quo[62:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `ADHM_ASSERT_IMP(a_done_idle, clk, rst, rsp.done, !busy)
endmodule
`default_nettype wire

// File: rtl/adhm_back.sv
// Back end: continued-fraction tangent, distance division and height product.
`timescale 1ns / 1ps
`default_nettype none
`include "angle_distance_height_meter_assert.svh"
module adhm_back
  import adhm_pkg::*;
#(
  parameter int CF_DEPTH = CF_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [SH_W-1:0] sensor_height,
  input  wire logic            q_empty,
  input  wire entry_t          q_data,
  output logic                 q_pop,
  output div_req_t             dv_req,
  input  wire div_rsp_t        dv_rsp,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output logic [39:0]          distance,
  output logic [39:0]          object_height,
  output logic                 status
);
  localparam int N_TERMS = 2 * CF_DEPTH - 1;
  localparam int ICNT_W = $clog2(N_TERMS + 1);
  localparam int ACC_W = 85;

  localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_TSTART = 4'd2, S_DIV_GO = 4'd3,
                         S_DIV_WAIT = 4'd4, S_TDONE = 4'd5, S_MUL_HI = 4'd6,
                         S_MUL_LO = 4'd7, S_FIN = 4'd8, S_OUT = 4'd9;
  localparam logic [1:0] K_CF = 2'd0, K_LAST = 2'd1, K_DIST = 2'd2;

  logic [3:0]          state;
  logic [1:0]          kind;
  logic                sel_b;
  logic                has_b;
  logic [ANGLE_W-1:0]  rb_r;
  logic [ANGLE_W-1:0]  x_r;
  logic [29:0]         x2_r;
  logic [28:0]         x28_r;
  logic [ICNT_W-1:0]   icnt;
  logic [31:0]         t_r;
  logic [63:0]         dist_r;
  logic [ACC_W-1:0]    acc;
  logic [63:0]         dvd;
  logic [63:0]         dvs;

  logic [49:0]         sq;
  logic [60:0]         prod_hi;
  logic [55:0]         prod_lo;
  logic [56:0]         hq;
  logic [57:0]         hsum;
  logic [31:0]         q_clamp;
  logic [39:0]         dist_clamp;

  function automatic logic [63:0] pos_div(input logic signed [64:0] d);
    return (d < 65'sd1) ? 64'd1 : d[63:0];
  endfunction

  function automatic logic [39:0] clamp40(input logic [63:0] v);
    return (v > {24'd0, OUT_MAX}) ? OUT_MAX : v[39:0];
  endfunction

  assign sq      = x_r * x_r;
  assign prod_hi = t_r * dist_r[52:24];
  assign prod_lo = t_r * dist_r[23:0];
  assign hq      = acc[ACC_W-1:TAN_FRAC];
  assign hsum    = {1'b0, hq} + 58'(sensor_height);
  assign q_clamp = (dv_rsp.quotient > TAN_MAX) ? 32'hFFFF_FFFF : dv_rsp.quotient[31:0];
  assign dist_clamp = clamp40(dist_r);

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign result_valid = state == S_OUT;
  assign dv_req.start = state == S_DIV_GO;
  assign dv_req.dividend = dvd;
  assign dv_req.divisor = dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_data.bad) begin
              distance      <= '0;
              object_height <= '0;
              status        <= 1'b1;
              state         <= S_OUT;
            end else begin
              x_r   <= q_data.ra;
              rb_r  <= q_data.rb;
              has_b <= q_data.has_b;
              sel_b <= 1'b0;
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          x2_r  <= sq[49:20];
          x28_r <= {x_r, 4'd0};
          state <= S_TSTART;
        end
        S_TSTART: begin
          if (N_TERMS <= 1) begin
            t_r   <= 32'(x28_r);
            state <= S_TDONE;
          end else begin
            dvd   <= {6'd0, x2_r, 28'd0};
            dvs   <= 64'(N_TERMS);
            icnt  <= ICNT_W'(N_TERMS - 2);
            kind  <= K_CF;
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (dv_rsp.done) begin
            case (kind)
              K_CF: begin
                state <= S_DIV_GO;
                if (icnt >= ICNT_W'(3)) begin
                  dvs  <= pos_div($signed({1'b0, 64'(icnt) << TAN_FRAC})
                                  - $signed({1'b0, dv_rsp.quotient}));
                  icnt <= icnt - ICNT_W'(2);
                end else begin
                  dvd  <= {7'd0, x28_r, 28'd0};
                  dvs  <= pos_div($signed({1'b0, ONE_Q28})
                                  - $signed({1'b0, dv_rsp.quotient}));
                  kind <= K_LAST;
                end
              end
              K_LAST: begin
                t_r   <= q_clamp;
                state <= S_TDONE;
              end
              default: begin
                dist_r <= dv_rsp.quotient;
                if (!has_b) begin
                  distance      <= clamp40(dv_rsp.quotient);
                  object_height <= '0;
                  status        <= 1'b0;
                  state         <= S_OUT;
                end else begin
                  x_r   <= rb_r;
                  sel_b <= 1'b1;
                  state <= S_SQ;
                end
              end
            endcase
          end
        end
        S_TDONE: begin
          if (!sel_b) begin
            dvd   <= {13'd0, sensor_height, 28'd0};
            dvs   <= {32'd0, t_r};
            kind  <= K_DIST;
            state <= S_DIV_GO;
          end else begin
            distance <= dist_clamp;
            status   <= 1'b0;
            if (dist_r > DIST_LIMIT) begin
              object_height <= OUT_MAX;
              state         <= S_OUT;
            end else begin
              state <= S_MUL_HI;
            end
          end
        end
        S_MUL_HI: begin
          acc   <= ACC_W'({prod_hi, 24'd0});
          state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          acc   <= acc + ACC_W'(prod_lo);
          state <= S_FIN;
        end
        S_FIN: begin
          if (hq >= 57'(OUT_MAX) || hsum > 58'(OUT_MAX)) object_height <= OUT_MAX;
          else object_height <= hsum[39:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!result_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ADHM_ASSERT_NXT(a_hold_result, clk, rst, result_valid && result_stall,
                   result_valid && $stable(distance) && $stable(object_height))
  `ADHM_ASSERT_IMP(a_no_div_in_out, clk, rst, result_valid, !dv_req.start && !q_pop)
endmodule
`default_nettype wire

// File: rtl/angle_distance_height_meter.sv
// Top level of the angle based distance and height meter.
`timescale 1ns / 1ps
`default_nettype none
// Usage: an item beat carries angle_a, angle_b and has_angle_b (signed Q8.24 radians).
// It is taken when item_valid is high and item_stall is low. Each item gives one
// result beat of distance, object_height (unsigned Q24.16, saturating) and status,
// taken when result_valid is high and result_stall is low.
// The front end folds both angles into the first quadrant with one subtraction of
// pi/2 per cycle, then hands the item to a two-entry queue. The back end evaluates
// the continued fraction with one shared 64-bit divider that yields one quotient
// bit per cycle. An item with angle B needs 2*CF_DEPTH+1 divisions, an item
// without it CF_DEPTH+1, and a rejected angle none.
// While the back end works or its result waits, the front end keeps accepting
// items until the queue is full. A stalled result holds steady.
// Reset empties the queue, drops any item in flight and sets sensor_height to 1.5.
// sensor_height is written through the APB port at byte address 0.
module angle_distance_height_meter
  import adhm_pkg::*;
#(
  parameter int CF_DEPTH = CF_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic signed [31:0] angle_a,
  input  wire logic signed [31:0] angle_b,
  input  wire logic               has_angle_b,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [39:0]             distance,
  output logic [39:0]             object_height,
  output logic                    status
);
  logic [SH_W-1:0] sensor_height;
  logic            reg_index;
  entry_t          push_data;
  entry_t          head;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  div_req_t        dv_req;
  div_rsp_t        dv_rsp;

  // Register index is the word address; only index zero exists.
  assign reg_index = paddr[2];
  assign pready = 1'b1;
  assign prdata = (reg_index == REG_SENSOR_HEIGHT) ? {9'd0, sensor_height} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_height <= SH_RESET;
    end else if (psel && penable && pwrite && pready && reg_index == REG_SENSOR_HEIGHT) begin
      sensor_height <= pwdata[SH_W-1:0];
    end
  end

  adhm_front u_front (
    .clk, .rst, .item_valid, .item_stall, .angle_a, .angle_b, .has_angle_b,
    .q_full, .q_push, .q_data(push_data)
  );

  adhm_queue u_queue (
    .clk, .rst, .push(q_push), .wdata(push_data), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(head)
  );

  adhm_div u_div (
    .clk, .rst, .req(dv_req), .rsp(dv_rsp)
  );

  adhm_back #(.CF_DEPTH(CF_DEPTH)) u_back (
    .clk, .rst, .sensor_height, .q_empty, .q_data(head), .q_pop,
    .dv_req, .dv_rsp, .result_valid, .result_stall, .distance, .object_height, .status
  );
endmodule
`default_nettype wire

// File: tb/sv/adhm_checker.sv
// Checker for the angle distance height meter: predicts each result and compares.
`timescale 1ns / 1ps
module adhm_checker
  import adhm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               item_valid,
  input  logic               item_stall,
  input  logic signed [31:0] angle_a,
  input  logic signed [31:0] angle_b,
  input  logic               has_angle_b,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic [39:0]        distance,
  input  logic [39:0]        object_height,
  input  logic               status,
  output int                 errors,
  output int                 pending
);
  localparam int     DEPTH = CF_DEPTH_DEF;
  localparam longint Q28 = longint'(1) << TAN_FRAC;
  localparam logic [2:0] SH_ADDR = 3'(4 * REG_SENSOR_HEIGHT);

  typedef struct packed {
    logic [39:0] dist_out;
    logic [39:0] height;
    logic        bad;
  } meas_t;

  meas_t            meas_q[$];
  logic [SH_W-1:0]  height_reg;

  // Folds an angle into the first quadrant; returns 1 when it lands in (0, 1.4].
  function automatic bit fold_angle(input longint a, output longint r);
    while (a > longint'(LIM_Q24))
      a -= longint'(HALFPI_Q24);
    r = a;
    return a > 0;
  endfunction

  // Continued fraction tangent of a Q8.24 angle, Q4.28 result with clamp.
  function automatic logic [63:0] tan_q28(input longint x);
    longint x28, x2, n, cf, i, d;
    logic [63:0] t;
    x28 = x * 16;
    x2  = (x * x) >>> 20;
    n   = 2 * DEPTH - 1;
    if (n <= 1)
      return (x28 > longint'(TAN_MAX)) ? TAN_MAX : 64'(x28);
    cf = (x2 * Q28) / n;
    for (i = n - 2; i >= 3; i -= 2) begin
      d = i * Q28 - cf;
      if (d < 1) d = 1;
      cf = (x2 * Q28) / d;
    end
    d = Q28 - cf;
    if (d < 1) d = 1;
    t = 64'((x28 * Q28) / d);
    return (t > TAN_MAX) ? TAN_MAX : t;
  endfunction

  function automatic meas_t measure(input logic signed [31:0] a, input logic signed [31:0] b,
                                    input logic use_b, input logic [SH_W-1:0] sh);
    meas_t       m;
    longint      ra, rb;
    logic [63:0] ta, tb, dist_full, phi, plo, q;
    m = '0;
    if (!fold_angle(longint'(a), ra)) begin
      m.bad = 1'b1;
      return m;
    end
    ta   = tan_q28(ra);
    dist_full = (ta == 0) ? '1 : ((64'(sh) << 28) / ta);
    m.dist_out = (dist_full > 64'(OUT_MAX)) ? OUT_MAX : dist_full[39:0];
    if (!use_b)
      return m;
    if (!fold_angle(longint'(b), rb)) begin
      m = '0;
      m.bad = 1'b1;
      return m;
    end
    tb = tan_q28(rb);
    if (dist_full > DIST_LIMIT) begin
      m.height = OUT_MAX;
    end else begin
      // Exact floor(tb * distance / 2^28) from two partial products.
      phi = tb * (dist_full >> 24);
      plo = tb * (dist_full & 64'hFF_FFFF);
      q   = (phi >> 4) + ((((phi & 64'hF) << 24) + plo) >> 28);
      if (q >= 64'(OUT_MAX)) m.height = OUT_MAX;
      else begin
        q = q + 64'(sh);
        m.height = (q > 64'(OUT_MAX)) ? OUT_MAX : q[39:0];
      end
    end
    return m;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = meas_q.size();

  always @(posedge clk) begin
    meas_t m;
    if (rst) begin
      meas_q.delete();
      height_reg <= SH_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr == SH_ADDR)
        height_reg <= pwdata[SH_W-1:0];
      if (item_valid && !item_stall)
        meas_q.push_back(measure(angle_a, angle_b, has_angle_b, height_reg));
      if (result_valid && !result_stall) begin
        if (meas_q.size() == 0) begin
          $display("%0t: result beat with no measurement pending", $time);
          errors++;
        end else begin
          m = meas_q.pop_front();
          if (status !== m.bad) report("status", 64'(status), 64'(m.bad));
          if (distance !== m.dist_out) report("distance", 64'(distance), 64'(m.dist_out));
          if (object_height !== m.height)
            report("object_height", 64'(object_height), 64'(m.height));
        end
      end
    end
  end
endmodule

// File: tb/sv/tb_angle_distance_height_meter.sv
// Testbench top of the angle distance height meter: stimulus and verdict.
`timescale 1ns / 1ps
module tb_angle_distance_height_meter;
  import adhm_pkg::*;

  // A beat with angle B needs 2*CF_DEPTH+1 divisions in the back end plus the angle
  // reduction, and the result side may stall for a while on top of that.
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 50;
  localparam logic [2:0] SH_ADDR = 3'(4 * REG_SENSOR_HEIGHT);
  localparam int LIM = 23488102;
  localparam int HALFPI = 26353589;

  logic               clk;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               item_valid, item_stall;
  logic signed [31:0] angle_a, angle_b;
  logic               has_angle_b;
  logic               result_valid, result_stall;
  logic [39:0]        distance, object_height;
  logic               status;
  int                 errors, pending;
  int                 idle_cycles;
  bit                 no_gaps;
  int                 stall_left;

  angle_distance_height_meter i_dut (.*);

  adhm_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random stalls on the result side: mostly short bursts, some long ones,
  // and stretches where the receiver never stalls at all.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin result_stall <= 1'b1; stall_left <= $urandom_range(0, 3); end
        3:       begin result_stall <= 1'b1; stall_left <= $urandom_range(10, 60); end
        4:       begin result_stall <= 1'b0; stall_left <= $urandom_range(200, 3000); end
        default: begin result_stall <= 1'b0; stall_left <= $urandom_range(0, 5); end
      endcase
    end
  end

  // Watchdog: counts cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_angle_distance_height_meter: FAIL");
      $finish;
    end
  end

  // Two-phase APB write; the register takes the value at the access edge.
  task automatic write_height(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SH_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Holds the sender until every pending measurement has come back, then lets
  // the block settle before anything touches the register. The count is first
  // read on a falling edge so that a beat taken at the last rising edge is seen.
  task automatic drain();
    @(negedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drives one beat until the edge that accepts it, then at times drops valid for a gap.
  // The stall is sampled on the falling edge, where nothing driven by the clock moves.
  task automatic send(input logic signed [31:0] a, input logic signed [31:0] b,
                      input logic use_b);
    bit   go;
    int   gap;
    item_valid  <= 1'b1;
    angle_a     <= a;
    angle_b     <= b;
    has_angle_b <= use_b;
    forever begin
      @(negedge clk);
      go = !item_stall;
      @(posedge clk);
      if (go) break;
    end
    gap = $urandom_range(0, 99);
    if (!no_gaps && gap >= 50) begin
      item_valid <= 1'b0;
      repeat ((gap < 90) ? $urandom_range(1, 3) : $urandom_range(10, 80)) @(posedge clk);
    end
  endtask

  // Angles that mostly fold into the first quadrant, with tiny angles for
  // saturation, fold boundaries and raw 32-bit noise mixed in.
  function automatic logic signed [31:0] pick_angle();
    int r;
    r = $urandom_range(0, 11);
    case (r)
      0, 1, 2, 3, 4: return $urandom_range(1, LIM);
      5, 6:          return $urandom_range(1, LIM) + $urandom_range(1, 3) * HALFPI;
      7:             return $urandom_range(1, LIM) + $urandom_range(4, 80) * HALFPI;
      8:             return $urandom_range(1, 2000);
      9:             return LIM + $urandom_range(0, 3) * HALFPI - 1 + $urandom_range(0, 2);
      default:       return $urandom();
    endcase
  endfunction

  task automatic random_run(input int count);
    repeat (count) begin
      if ($urandom_range(0, 49) == 0) no_gaps = !no_gaps;
      send(pick_angle(), pick_angle(), $urandom_range(0, 9) < 6);
    end
    item_valid <= 1'b0;
  endtask

  initial begin
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    item_valid  <= 1'b0;
    angle_a     <= '0;
    angle_b     <= '0;
    has_angle_b <= 1'b0;
    no_gaps     = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats at the reset height: fold boundaries, rejected angles on
    // either side, angle B ignored when absent, and saturation from tiny angles.
    send(32'sd1, 32'sd1, 1'b1);
    send(LIM, LIM, 1'b1);
    send(LIM + 1, 32'sd1000000, 1'b1);
    send(LIM + HALFPI, LIM, 1'b1);
    send(32'sd0, 32'sd5000000, 1'b1);
    send(32'sd10000000, 32'sd0, 1'b1);
    send(32'sd10000000, 32'sd0, 1'b0);
    send(32'sd10000000, 32'h8000_0000, 1'b0);
    send(32'sh7FFF_FFFF, 32'sd12000000, 1'b1);
    send(32'sh8000_0000, 32'sd12000000, 1'b1);
    send(-32'sd1, 32'sd12000000, 1'b0);
    send(32'sd12000000, 32'sh7FFF_FFFF, 1'b1);
    send(32'sd12000000, -32'sd5, 1'b1);
    send(32'sd3, LIM, 1'b1);
    send(LIM, 32'sd3, 1'b1);
    send(32'sd20000000, 32'sd23000000, 1'b1);
    item_valid <= 1'b0;

    // The sender waits here for every result before going on.
    drain();
    write_height(32'd6553600);
    send(32'sd1, LIM, 1'b1);
    send(LIM, LIM, 1'b1);
    random_run(240);

    drain();
    write_height(32'd1);
    random_run(240);

    drain();
    write_height(32'($urandom_range(1, 6553600)));
    random_run(240);

    // A zero height is used as written, so every distance comes out zero.
    drain();
    write_height(32'd0);
    random_run(10);

    drain();
    if (errors == 0 && pending == 0)
      $display("tb_angle_distance_height_meter: PASS");
    else
      $display("tb_angle_distance_height_meter: FAIL");
    $finish;
  end
endmodule
